### design/hptm_pkg.sv
package hptm_pkg;

  // Word layouts
  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int LEVELS    = 255;
  localparam int STEPS     = 8;    // binary search steps, one per stage
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic [WORD_W-1:0] red;
    logic [WORD_W-1:0] green;
    logic [WORD_W-1:0] blue;
    logic [WORD_W-1:0] alpha;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] alpha_byte;
  } out_word_t;

  typedef logic [NUM_LANES-1:0][BYTE_W-1:0] lane_bytes_t;
  typedef logic [LEVELS-1:0][WORD_W-1:0] thr_tab_t;

  // Float bit pattern of +infinity; anything above it is NaN
  localparam logic [WORD_W-1:0] POS_INF = 32'h7F80_0000;

  // Q30 fixed point used to build the threshold tables
  localparam int FRAC = 30;
  localparam logic [63:0] ONE      = 64'd1 << FRAC;
  localparam logic [63:0] LN2_Q    = 64'd744261118;
  localparam logic [63:0] CURVE_Q  = 64'd198506946;
  localparam longint      EXPO_Q   = 64'sd3730103935;
  localparam longint      POW_NUM  = 64'sd2000;
  localparam longint      POW_DEN  = 64'sd909;
  localparam logic [63:0] SCALE_NUM = 64'd4233;
  localparam logic [63:0] SCALE_DEN = 64'd50;
  localparam logic [63:0] ALPHA_DEN = 64'd255;

  // Shift-subtract long division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^t by truncated Taylor series, argument saturates at 3.0
  function automatic logic [63:0] exp_q(input logic [63:0] t);
    logic [63:0] tt;
    logic [63:0] sum;
    logic [63:0] term;
    logic        done;
    tt = t;
    if (tt > 3 * ONE) tt = 3 * ONE;
    sum  = ONE;
    term = ONE;
    done = 1'b0;
    for (int n = 1; n <= 48; n++) begin
      if (!done) begin
        term = udiv((term * tt) >> FRAC, 64'(n));
        if (term == '0) done = 1'b1;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  // log2 in Q30: integer part from leading one, fraction by repeated squaring
  function automatic longint log2_q(input logic [63:0] x);
    int          p;
    logic [63:0] m;
    logic [63:0] r;
    longint      res;
    p = 0;
    for (int i = 1; i < 64; i++) begin
      if (x[i]) p = i;
    end
    m = (p >= FRAC) ? (x >> (p - FRAC)) : (x << (FRAC - p));
    r = '0;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> FRAC;
      r = r << 1;
      if (m >= 2 * ONE) begin
        m = m >> 1;
        r = r | 64'd1;
      end
    end
    if (x == '0) return 0;
    res = 64'(p - FRAC);
    res = res * longint'(ONE) + longint'(r);
    return res;
  endfunction

  // 2^y as a float, mantissa rounded up to 23 bits
  function automatic logic [WORD_W-1:0] float_of_log2(input longint y);
    longint      e;
    logic [63:0] f;
    logic [63:0] mant;
    logic [63:0] m23;
    e    = y >>> FRAC;
    f    = 64'(y) & (ONE - 64'd1);
    mant = exp_q((f * LN2_Q) >> FRAC);
    if (mant >= 2 * ONE) begin
      mant = mant >> 1;
      e    = e + 1;
    end
    m23 = (mant + 64'd127) >> 7;
    if (m23 >= (64'd1 << 24)) begin
      m23 = m23 >> 1;
      e   = e + 1;
    end
    if (e < -126) e = -126;
    if (e > 127) e = 127;
    return {1'b0, 8'(e + 127), m23[22:0]};
  endfunction

  // Colour thresholds: smallest float reaching each byte level
  function automatic thr_tab_t build_col();
    thr_tab_t    tab;
    longint      base_log;
    longint      lg;
    logic [63:0] ulg;
    logic [63:0] g;
    logic [63:0] t;
    logic [63:0] h;
    base_log = log2_q(SCALE_NUM << FRAC);
    for (int k = 1; k <= LEVELS; k++) begin
      lg = log2_q((64'(k) * SCALE_DEN) << FRAC) - base_log;
      lg = lg * POW_NUM / POW_DEN;
      if (lg > 0) begin
        ulg = 64'(lg);
        g   = exp_q((ulg * LN2_Q) >> FRAC);
        t   = ((g - ONE) * CURVE_Q) >> FRAC;
        h   = ((exp_q(t) - ONE) << FRAC) / CURVE_Q + ONE;
        lg  = log2_q(h);
      end
      tab[k-1] = float_of_log2(lg - EXPO_Q);
    end
    return tab;
  endfunction

  // Alpha thresholds: exact ceiling of k/255 as a float
  function automatic thr_tab_t build_alp();
    thr_tab_t    tab;
    int          s;
    logic [63:0] m;
    for (int k = 1; k <= LEVELS; k++) begin
      s = 0;
      for (int j = 0; j < 8; j++) begin
        if ((64'(k) << s) < 64'd255) s = s + 1;
      end
      m = ((64'(k) << (s + 23)) + 64'd254) / ALPHA_DEN;
      tab[k-1] = {1'b0, 8'(127 - s), m[22:0]};
    end
    return tab;
  endfunction

  localparam thr_tab_t COL_TAB = build_col();
  localparam thr_tab_t ALP_TAB = build_alp();

endpackage

### design/hptm_lane.sv
// One channel: 8-stage binary search over the ascending threshold table.
// The byte is the count of thresholds at or below the input bits.
module hptm_lane #(
  parameter bit ALPHA_LANE = 1'b0
) (
  input  logic                       clk,
  input  logic [hptm_pkg::WORD_W-1:0] x_i,
  output logic [hptm_pkg::BYTE_W-1:0] byte_o
);

  localparam int STEPS = hptm_pkg::STEPS;
  localparam hptm_pkg::thr_tab_t TAB = ALPHA_LANE ? hptm_pkg::ALP_TAB : hptm_pkg::COL_TAB;

  logic [hptm_pkg::WORD_W-1:0] x_clean;
  logic [hptm_pkg::WORD_W-1:0] x_r   [STEPS-1];
  logic [hptm_pkg::BYTE_W-1:0] n_r   [STEPS];
  logic [hptm_pkg::BYTE_W-1:0] n_nxt [STEPS];

  // Negative values and NaN map to zero, which lies below every threshold
  assign x_clean = (x_i[hptm_pkg::WORD_W-1] || (x_i > hptm_pkg::POS_INF)) ? '0 : x_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [hptm_pkg::WORD_W-1:0] x_in;
    logic [hptm_pkg::BYTE_W-1:0] n_in;
    logic [hptm_pkg::BYTE_W-1:0] cand;

    if (i == 0) begin : g_first
      assign x_in = x_clean;
      assign n_in = '0;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign n_in = n_r[i-1];
    end

    // Try setting this stage's bit of the count
    assign cand = n_in | (8'd1 << (STEPS - 1 - i));

    always_comb begin
      n_nxt[i] = (x_in >= TAB[cand - 8'd1]) ? cand : n_in;
    end

    always_ff @(posedge clk) begin
      n_r[i] <= n_nxt[i];
    end

    if (i < STEPS - 1) begin : g_xreg
      always_ff @(posedge clk) begin
        x_r[i] <= x_in;
      end
    end
  end

  assign byte_o = n_r[STEPS-1];

endmodule

### design/hptm_merge.sv
// Gathers the four lane bytes into one result word and registers it.
module hptm_merge (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  hptm_pkg::lane_bytes_t   lane_i,
  output logic                    out_valid_o,
  output hptm_pkg::out_word_t     out_word_o
);

  hptm_pkg::out_word_t word_nxt;
  hptm_pkg::out_word_t word_r;
  logic                valid_r;

  always_comb begin
    word_nxt.red_byte   = lane_i[0];
    word_nxt.green_byte = lane_i[1];
    word_nxt.blue_byte  = lane_i[2];
    word_nxt.alpha_byte = lane_i[3];
  end

  // Strobe: control, reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_i;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid_o = valid_r;
  assign out_word_o  = word_r;

endmodule

### design/hdr_pixel_tone_map_to_bytes_unit.sv
// HDR pixel to four bytes by knee-and-gamma tone mapping.
// Input channel: in_word carries red, green, blue and alpha as float bit
// patterns; a word is taken at each rising edge with start high and busy low.
// busy is always low, so a new pixel may be given every cycle.
// Result channel: out_word carries four bytes for one clock cycle, marked by
// out_valid. The receiver cannot stall; each result must be taken when shown.
// A pixel accepted at one edge passes through 8 search stages and then an output
// register before its bytes show on out_word. Throughput: one pixel per clock.
// Each channel runs in its own lane: an 8-step binary search against 255
// ascending thresholds, one step per pipeline stage, so every lane holds up
// to 8 pixels in flight. Negative, zero and NaN inputs give 0; +inf gives 255.
// Reset (rst_n low, synchronous) clears the valid pipeline: pixels in flight
// are dropped and out_valid is low until new pixels come through.
module hdr_pixel_tone_map_to_bytes_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hptm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output hptm_pkg::out_word_t  out_word
);

  localparam int STEPS = hptm_pkg::STEPS;

  logic                  accept;
  logic [STEPS-1:0]      vld_r;
  logic [STEPS-1:0]      vld_nxt;
  hptm_pkg::lane_bytes_t lane_bytes;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid tracks the pixel down the search stages
  assign vld_nxt = {vld_r[STEPS-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Colour lanes share one table, alpha uses its own
  hptm_lane #(.ALPHA_LANE(1'b0)) u_lane_red (
    .clk    (clk),
    .x_i    (in_word.red),
    .byte_o (lane_bytes[0])
  );

  hptm_lane #(.ALPHA_LANE(1'b0)) u_lane_green (
    .clk    (clk),
    .x_i    (in_word.green),
    .byte_o (lane_bytes[1])
  );

  hptm_lane #(.ALPHA_LANE(1'b0)) u_lane_blue (
    .clk    (clk),
    .x_i    (in_word.blue),
    .byte_o (lane_bytes[2])
  );

  hptm_lane #(.ALPHA_LANE(1'b1)) u_lane_alpha (
    .clk    (clk),
    .x_i    (in_word.alpha),
    .byte_o (lane_bytes[3])
  );

  hptm_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_r[STEPS-1]),
    .lane_i      (lane_bytes),
    .out_valid_o (out_valid),
    .out_word_o  (out_word)
  );

endmodule

### design/hptm_checker.sv
module hptm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input hptm_pkg::in_word_t  in_word,
  input logic                out_valid,
  input hptm_pkg::out_word_t out_word
);

  // Every accepted pixel yields a result after the search stages and output register
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_valid)
    else $error("accepted pixel produced no result");

  // No result without a matching accepted pixel earlier in the pipeline
  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 9))
    else $error("result without an accepted pixel");

  // Negative red input maps to zero
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.red[31]) |-> ##9 (out_word.red_byte == 8'd0))
    else $error("negative red did not give zero");

  // Infinite alpha saturates
  a_inf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.alpha == hptm_pkg::POS_INF))
      |-> ##9 (out_word.alpha_byte == 8'd255))
    else $error("infinite alpha did not saturate");

endmodule

bind hdr_pixel_tone_map_to_bytes_unit hptm_checker u_hptm_checker (.*);

### tb/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;   // pipeline is 9 deep

  // Q30 constants of the threshold arithmetic
  localparam int FRAC_BITS = 30;
  localparam bit [63:0] UNIT = 64'd1 << FRAC_BITS;
  localparam longint UNIT_S = 64'sd1073741824;
  localparam bit [63:0] LN2_FIX = 64'd744261118;
  localparam bit [63:0] KNEE_FIX = 64'd198506946;
  localparam longint PRE_SCALE_LOG2 = 64'sd3730103935;
  localparam longint GAMMA_NUM = 64'sd2000;
  localparam longint GAMMA_DEN = 64'sd909;
  localparam bit [63:0] GAIN_NUM = 64'd4233;
  localparam bit [63:0] GAIN_DEN = 64'd50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  hptm_pkg::in_word_t in_word = '0;
  logic out_valid;
  hptm_pkg::out_word_t out_word;

  hptm_pkg::thr_tab_t col_thresh;
  hptm_pkg::thr_tab_t alpha_thresh;
  hptm_pkg::out_word_t pending_bytes[$];
  hptm_pkg::out_word_t want;
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int cycle_count = 0;

  hdr_pixel_tone_map_to_bytes_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // e^t, truncated Taylor terms, argument capped at 3.0
  function automatic bit [63:0] taylor_exp(input bit [63:0] arg);
    bit [63:0] t;
    bit [63:0] acc;
    bit [63:0] term;
    t = arg;
    if (t > 3 * UNIT) t = 3 * UNIT;
    acc = UNIT;
    term = UNIT;
    for (int n = 1; n <= 48; n++) begin
      term = ((term * t) >> FRAC_BITS) / 64'(n);
      if (term == 64'd0) break;
      acc = acc + term;
    end
    return acc;
  endfunction

  // log2 in Q30: leading one gives the integer part, squaring the fraction
  function automatic longint fixed_log2(input bit [63:0] x);
    int lead;
    bit [63:0] m;
    bit [63:0] r;
    if (x == 64'd0) return 0;
    lead = 0;
    for (int i = 1; i < 64; i++) begin
      if (x[i]) lead = i;
    end
    m = (lead >= FRAC_BITS) ? (x >> (lead - FRAC_BITS)) : (x << (FRAC_BITS - lead));
    r = 64'd0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> FRAC_BITS;
      r = r << 1;
      if (m >= 2 * UNIT) begin
        m = m >> 1;
        r = r | 64'd1;
      end
    end
    return longint'(lead - FRAC_BITS) * UNIT_S + longint'(r);
  endfunction

  // 2^y as a float bit pattern, mantissa rounded up
  function automatic bit [31:0] pow2_to_float(input longint y);
    longint e;
    longint f;
    bit [63:0] fu;
    bit [63:0] mant;
    bit [63:0] m23;
    if (y >= 0) e = y / UNIT_S;
    else e = -((-y + UNIT_S - 1) / UNIT_S);
    f = y - e * UNIT_S;
    fu = f;
    mant = taylor_exp((fu * LN2_FIX) >> FRAC_BITS);
    if (mant >= 2 * UNIT) begin
      mant = mant >> 1;
      e = e + 1;
    end
    m23 = (mant + 64'd127) >> 7;
    if (m23 >= (64'd1 << 24)) begin
      m23 = m23 >> 1;
      e = e + 1;
    end
    if (e < -126) e = -126;
    if (e > 127) e = 127;
    return {1'b0, 8'(e + 127), m23[22:0]};
  endfunction

  // Smallest float reaching each byte level, colour and alpha
  task automatic build_thresholds();
    longint base_lg;
    longint lg;
    bit [63:0] ulg;
    bit [63:0] g;
    bit [63:0] t;
    bit [63:0] h;
    bit [63:0] m;
    int s;
    base_lg = fixed_log2(GAIN_NUM << FRAC_BITS);
    for (int k = 1; k <= hptm_pkg::LEVELS; k++) begin
      lg = fixed_log2((64'(k) * GAIN_DEN) << FRAC_BITS) - base_lg;
      lg = lg * GAMMA_NUM / GAMMA_DEN;
      if (lg > 0) begin
        // undo the knee above 1
        ulg = lg;
        g = taylor_exp((ulg * LN2_FIX) >> FRAC_BITS);
        t = ((g - UNIT) * KNEE_FIX) >> FRAC_BITS;
        h = ((taylor_exp(t) - UNIT) << FRAC_BITS) / KNEE_FIX + UNIT;
        lg = fixed_log2(h);
      end
      col_thresh[k-1] = pow2_to_float(lg - PRE_SCALE_LOG2);
      s = 0;
      while ((64'(k) << s) < 64'd255) s++;
      m = ((64'(k) << (s + 23)) + 64'd254) / 64'd255;
      alpha_thresh[k-1] = {1'b0, 8'(127 - s), m[22:0]};
    end
  endtask

  // Byte = number of thresholds at or below the input; sign and NaN give 0
  function automatic bit [7:0] level_count(input bit [31:0] x,
                                           input hptm_pkg::thr_tab_t tab);
    int n;
    if (x[31]) return 8'd0;
    if (x > hptm_pkg::POS_INF) return 8'd0;
    n = 0;
    for (int i = 0; i < hptm_pkg::LEVELS; i++) begin
      if (x >= tab[i]) n++;
    end
    return n[7:0];
  endfunction

  function automatic hptm_pkg::out_word_t tone_map_pixel(input hptm_pkg::in_word_t px);
    hptm_pkg::out_word_t r;
    r.red_byte = level_count(px.red, col_thresh);
    r.green_byte = level_count(px.green, col_thresh);
    r.blue_byte = level_count(px.blue, col_thresh);
    r.alpha_byte = level_count(px.alpha, alpha_thresh);
    return r;
  endfunction

  // One channel: raw bits, near a level edge, useful range, or an odd value
  function automatic bit [31:0] rand_channel(input bit for_alpha);
    int pick;
    hptm_pkg::thr_tab_t tab;
    tab = for_alpha ? alpha_thresh : col_thresh;
    pick = $urandom_range(0, 99);
    if (pick < 25) return $urandom();
    if (pick < 60)
      return tab[$urandom_range(0, hptm_pkg::LEVELS - 1)] + 32'($urandom_range(0, 4)) - 32'd2;
    if (pick < 90) begin
      if (for_alpha) return {1'b0, 8'($urandom_range(110, 128)), 23'($urandom())};
      return {1'b0, 8'($urandom_range(100, 140)), 23'($urandom())};
    end
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return hptm_pkg::POS_INF;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000 | 32'($urandom_range(0, 255));
      5: return 32'h7F7F_FFFF;
      6: return 32'h007F_FFFF;
      default: return 32'h3F80_0000;
    endcase
  endfunction

  function automatic hptm_pkg::in_word_t rand_pixel();
    return {rand_channel(1'b0), rand_channel(1'b0), rand_channel(1'b0), rand_channel(1'b1)};
  endfunction

  // Send one word; start stays high so back-to-back words need no gap
  task automatic send_pixel(input hptm_pkg::in_word_t w);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    pending_bytes.push_back(tone_map_pixel(w));
    sent_count++;
  endtask

  // Sender gap, with junk on the data lines
  task automatic idle_burst(input int n);
    start <= 1'b0;
    in_word <= {$urandom(), $urandom(), $urandom(), $urandom()};
    repeat (n) @(posedge clk);
  endtask

  task automatic test_special_values();
    send_pixel({32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FC0_0000});
    send_pixel({hptm_pkg::POS_INF, 32'hFF80_0000, 32'hFFC0_0000, 32'h3F80_0000});
    send_pixel({32'h7F7F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'h4000_0000});
    send_pixel({32'h7FFF_FFFF, 32'h7F80_0001, 32'hFFFF_FFFF, hptm_pkg::POS_INF});
    send_pixel({32'h3F80_0000, 32'h4120_0000, 32'h3DCC_CCCD, 32'h3F00_0000});
    send_pixel({32'h8000_0001, 32'h0000_0000, hptm_pkg::POS_INF, 32'h8000_0000});
    send_pixel({32'h3A00_0000, 32'h38D1_B717, 32'h42C8_0000, 32'h0000_0000});
  endtask

  // Exact level edges and values just below and above them
  task automatic test_threshold_edges();
    int ks[5];
    int k;
    ks = '{1, 2, 128, 254, 255};
    for (int i = 0; i < 5; i++) begin
      k = ks[i] - 1;
      send_pixel({col_thresh[k], col_thresh[k] - 32'd1, col_thresh[k] + 32'd1, alpha_thresh[k]});
      send_pixel({col_thresh[k] - 32'd1, col_thresh[k], col_thresh[k] - 32'd2,
                  alpha_thresh[k] - 32'd1});
    end
  endtask

  // Blocks of traffic, some with random gaps, some dense
  task automatic test_random_traffic();
    bit gappy;
    for (int blk = 0; blk < 22; blk++) begin
      gappy = $urandom_range(0, 3) != 0;
      repeat (50) begin
        if (gappy && $urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 5));
        send_pixel(rand_pixel());
      end
    end
  endtask

  // Sender holds off until the pipeline has emptied
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (15) send_pixel(rand_pixel());
      start <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_back_to_back();
    repeat (300) send_pixel(rand_pixel());
  endtask

  // Result checker: every strobed word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %h", out_word);
      end else begin
        want = pending_bytes.pop_front();
        checked_count++;
        if (out_word.red_byte !== want.red_byte || out_word.green_byte !== want.green_byte ||
            out_word.blue_byte !== want.blue_byte || out_word.alpha_byte !== want.alpha_byte) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch at result %0d: exp r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                     checked_count, want.red_byte, want.green_byte, want.blue_byte,
                     want.alpha_byte, out_word.red_byte, out_word.green_byte,
                     out_word.blue_byte, out_word.alpha_byte);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    build_thresholds();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_special_values();
    test_threshold_edges();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels: special floats, level edges, random traffic with and without gaps",
             sent_count);
    $display("Checked %0d result words, %0d failures", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/hptm_pkg.sv
design/hptm_lane.sv
design/hptm_merge.sv
design/hdr_pixel_tone_map_to_bytes_unit.sv
design/hptm_checker.sv
tb/testbench.sv
